// ===== hdl/cor_pkg.sv =====
// Shared constants, payload types and helpers for the channelizer output rotator.
package cor_pkg;

    localparam int LANES        = 8;
    localparam int CHANNELS     = 16;
    localparam int SAMPLE_WIDTH = 32;
    localparam int WORD_SAMPLES = 4;
    localparam int VECTORS      = 2;
    localparam int PARITIES     = 2;
    localparam int BANKS        = 2;
    localparam int DELAY_DEPTH  = 4;
    localparam int LANE_W       = $clog2(LANES);
    localparam int CH_W         = $clog2(CHANNELS);
    localparam int ROT_W        = CH_W - 1;
    localparam int HALF_W       = 2 * SAMPLE_WIDTH;

    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);

    typedef logic [SAMPLE_WIDTH-1:0] t_sample;

    typedef struct packed {
        logic [LANE_W-1:0] lane;
        logic [HALF_W-1:0] word_low;
        logic [HALF_W-1:0] word_high;
    } t_in_item;

    typedef struct packed {
        logic [LANE_W-1:0] out_lane;
        logic [HALF_W-1:0] out_low;
        logic [HALF_W-1:0] out_high;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic bank;
        logic odd;
    } t_lane_ctl;

    typedef t_sample [VECTORS-1:0][PARITIES-1:0] t_lane_late;

    function automatic int ptr_width(int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== hdl/cor_ifs.sv =====
// Valid/ready stream interfaces for the lane-word input and result output.
interface cor_in_if ();
    logic              valid;
    logic              ready;
    cor_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cor_out_if ();
    logic               valid;
    logic               ready;
    cor_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cor_lane.sv =====
// Lane cell: ping-pong banks and delay slots for the two channels of one lane.
module cor_lane #(
    parameter int DELAY_DEPTH = cor_pkg::DELAY_DEPTH
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  cor_pkg::t_lane_ctl                                   i_ctl,
    input  logic [cor_pkg::ptr_width(DELAY_DEPTH)-1:0]           i_dptr,
    input  cor_pkg::t_sample [cor_pkg::WORD_SAMPLES-1:0]         i_samples,
    output cor_pkg::t_lane_late                                  o_late
);

    cor_pkg::t_sample r_pp [cor_pkg::WORD_SAMPLES][cor_pkg::PARITIES][cor_pkg::BANKS];
    cor_pkg::t_sample r_dl [cor_pkg::VECTORS][cor_pkg::PARITIES][DELAY_DEPTH];
    cor_pkg::t_lane_late r_late;
    cor_pkg::t_lane_late fresh;

    always_comb begin
        for (int v = 0; v < cor_pkg::VECTORS; v++) begin
            for (int p = 0; p < cor_pkg::PARITIES; p++) begin
                fresh[v][p] = r_pp[{i_ctl.odd, 1'(v)}][p][~i_ctl.bank];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cor_pkg::WORD_SAMPLES; k++) begin
                for (int p = 0; p < cor_pkg::PARITIES; p++) begin
                    for (int b = 0; b < cor_pkg::BANKS; b++) begin
                        r_pp[k][p][b] <= '0;
                    end
                end
            end
            for (int v = 0; v < cor_pkg::VECTORS; v++) begin
                for (int p = 0; p < cor_pkg::PARITIES; p++) begin
                    for (int s = 0; s < DELAY_DEPTH; s++) begin
                        r_dl[v][p][s] <= '0;
                    end
                end
            end
        end else begin
            if (i_ctl.wr_en) begin
                for (int k = 0; k < cor_pkg::WORD_SAMPLES; k++) begin
                    r_pp[k][i_ctl.odd][i_ctl.bank] <= i_samples[k];
                end
            end
            if (i_ctl.rd_en) begin
                for (int v = 0; v < cor_pkg::VECTORS; v++) begin
                    for (int p = 0; p < cor_pkg::PARITIES; p++) begin
                        r_dl[v][p][i_dptr] <= fresh[v][p];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            for (int v = 0; v < cor_pkg::VECTORS; v++) begin
                for (int p = 0; p < cor_pkg::PARITIES; p++) begin
                    r_late[v][p] <= r_dl[v][p][i_dptr];
                end
            end
        end
    end

    assign o_late = r_late;

endmodule

// ===== hdl/cor_merge.sv =====
// Merge stage: rotate the lane outputs into two vectors and serialize eight result words.
module cor_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_capture,
    input  logic [cor_pkg::CH_W-1:0]      i_shift_a,
    input  logic [cor_pkg::CH_W-1:0]      i_shift_b,
    input  cor_pkg::t_lane_late           i_late [cor_pkg::LANES],
    output logic                          o_can_capture,
    cor_out_if.source                     o_out
);

    logic                          r_stage_v;
    logic                          r_ser_v;
    logic [cor_pkg::LANE_W-1:0]    r_cnt;
    logic [cor_pkg::CH_W-1:0]      r_shift_a;
    logic [cor_pkg::CH_W-1:0]      r_shift_b;
    logic [cor_pkg::HALF_W-1:0]    r_lo [cor_pkg::LANES];
    logic [cor_pkg::HALF_W-1:0]    r_hi [cor_pkg::LANES];

    cor_pkg::t_sample              rot_a [cor_pkg::CHANNELS];
    cor_pkg::t_sample              rot_b [cor_pkg::CHANNELS];
    logic [cor_pkg::HALF_W-1:0]    n_lo [cor_pkg::LANES];
    logic [cor_pkg::HALF_W-1:0]    n_hi [cor_pkg::LANES];
    logic [cor_pkg::CH_W-1:0]      src_a [cor_pkg::CHANNELS];
    logic [cor_pkg::CH_W-1:0]      src_b [cor_pkg::CHANNELS];
    logic                          out_acc;
    logic                          last_acc;
    logic                          load;

    always_comb begin
        for (int m = 0; m < cor_pkg::CHANNELS; m++) begin
            src_a[m] = cor_pkg::CH_W'(m) + r_shift_a;
            src_b[m] = cor_pkg::CH_W'(m) + r_shift_b;
            rot_a[m] = i_late[src_a[m][cor_pkg::CH_W-1:1]][0][src_a[m][0]];
            rot_b[m] = i_late[src_b[m][cor_pkg::CH_W-1:1]][1][src_b[m][0]];
        end
        for (int i = 0; i < cor_pkg::LANES; i++) begin
            n_lo[i] = {rot_a[i + cor_pkg::LANES], rot_a[i]};
            n_hi[i] = {rot_b[i + cor_pkg::LANES], rot_b[i]};
        end
    end

    assign out_acc       = r_ser_v && o_out.ready;
    assign last_acc      = out_acc && (r_cnt == cor_pkg::LAST_LANE);
    assign load          = r_stage_v && (!r_ser_v || last_acc);
    assign o_can_capture = !r_stage_v || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_v <= 1'b0;
            r_ser_v   <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (i_capture) begin
                r_stage_v <= 1'b1;
            end else if (load) begin
                r_stage_v <= 1'b0;
            end
            if (load) begin
                r_ser_v <= 1'b1;
                r_cnt   <= '0;
            end else if (last_acc) begin
                r_ser_v <= 1'b0;
                r_cnt   <= '0;
            end else if (out_acc) begin
                r_cnt <= r_cnt + cor_pkg::LANE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_shift_a <= i_shift_a;
            r_shift_b <= i_shift_b;
        end
        if (load) begin
            for (int i = 0; i < cor_pkg::LANES; i++) begin
                r_lo[i] <= n_lo[i];
                r_hi[i] <= n_hi[i];
            end
        end else if (out_acc) begin
            for (int i = 0; i < cor_pkg::LANES - 1; i++) begin
                r_lo[i] <= r_lo[i + 1];
                r_hi[i] <= r_hi[i + 1];
            end
        end
    end

    assign o_out.valid         = r_ser_v;
    assign o_out.data.out_lane = r_cnt;
    assign o_out.data.out_low  = r_lo[0];
    assign o_out.data.out_high = r_hi[0];
    assign o_out.data.last     = (r_cnt == cor_pkg::LAST_LANE);

`ifndef SYNTHESIS
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_ser_v && r_cnt == '0))
        else $error("serializer did not start at result zero after load");
    a_capture_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_capture |=> r_stage_v)
        else $error("captured group not held in stage");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage_v && !load) |-> !i_capture)
        else $error("new group captured over a pending group");
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ser_v |-> (r_cnt == '0))
        else $error("result count nonzero while serializer idle");
    a_mid_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_cnt != cor_pkg::LAST_LANE) |=> r_ser_v)
        else $error("serializer dropped a group before its last result");
`endif

endmodule

// ===== hdl/channelizer_output_rotator.sv =====
// Top level of the channelizer output rotator: eight lane cells and a merge stage.
//
//   port    dir  modport  payload
//   i_in    in   sink     lane, word_low, word_high
//   o_out   out  source   out_lane, out_low, out_high, last
//
// One lane word is accepted per cycle, sustained, while i_in.ready is high.
// A lane-7 word reads all 16 channels from the eight lane cells at its accept edge;
// its group is staged, then results leave one per cycle while o_out.ready is high.
// Reset is synchronous and clears banks and delay slots in flip-flops at once.
// i_in.ready drops only while a captured group waits behind a group still draining.
module channelizer_output_rotator #(
    parameter int DELAY_DEPTH = cor_pkg::DELAY_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cor_in_if.sink    i_in,
    cor_out_if.source o_out
);

    localparam int DP_W = cor_pkg::ptr_width(DELAY_DEPTH);

    logic                          r_odd;
    logic                          r_bank;
    logic [DP_W-1:0]               r_dptr;
    logic [cor_pkg::ROT_W-1:0]     r_rot;

    logic                          in_acc;
    logic                          capture;
    logic                          can_capture;
    logic [cor_pkg::CH_W-1:0]      shift_a;
    logic [cor_pkg::CH_W-1:0]      shift_b;
    cor_pkg::t_sample [cor_pkg::WORD_SAMPLES-1:0] samples;
    cor_pkg::t_lane_late           lane_late [cor_pkg::LANES];

    assign i_in.ready = can_capture;
    assign in_acc     = i_in.valid && can_capture;
    assign capture    = in_acc && (i_in.data.lane == cor_pkg::LAST_LANE);
    assign samples    = {i_in.data.word_high, i_in.data.word_low};
    assign shift_a    = {r_rot, 1'b0};
    assign shift_b    = {r_rot + cor_pkg::ROT_W'(1), 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_odd  <= 1'b0;
            r_bank <= 1'b0;
            r_dptr <= '0;
            r_rot  <= '0;
        end else if (capture) begin
            r_odd <= ~r_odd;
            if (r_odd) begin
                r_bank <= ~r_bank;
            end
            if (r_dptr == DP_W'(DELAY_DEPTH - 1)) begin
                r_dptr <= '0;
            end else begin
                r_dptr <= r_dptr + DP_W'(1);
            end
            r_rot <= r_rot + cor_pkg::ROT_W'(2);
        end
    end

    for (genvar g = 0; g < cor_pkg::LANES; g++) begin : g_lane
        cor_pkg::t_lane_ctl ctl;

        assign ctl.wr_en = in_acc && (i_in.data.lane == cor_pkg::LANE_W'(g));
        assign ctl.rd_en = capture;
        assign ctl.bank  = r_bank;
        assign ctl.odd   = r_odd;

        cor_lane #(
            .DELAY_DEPTH (DELAY_DEPTH)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_dptr    (r_dptr),
            .i_samples (samples),
            .o_late    (lane_late[g])
        );
    end

    cor_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_capture     (capture),
        .i_shift_a     (shift_a),
        .i_shift_b     (shift_b),
        .i_late        (lane_late),
        .o_can_capture (can_capture),
        .o_out         (o_out)
    );

endmodule

// ===== tb/sv/channelizer_output_rotator_test.sv =====
// Self-checking regression bench for the channelizer output rotator, with a built-in predictor.
module channelizer_output_rotator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    cor_in_if  in_bus ();
    cor_out_if out_bus ();

    channelizer_output_rotator #(
        .DELAY_DEPTH(cor_pkg::DELAY_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    int src_idle_pct;
    int snk_stall_pct;
    int mismatch_count;
    int cycle_count;

    cor_pkg::t_out_item rotated_words_q [$];

    cor_pkg::t_sample bank_mem  [cor_pkg::BANKS][cor_pkg::WORD_SAMPLES][cor_pkg::CHANNELS];
    cor_pkg::t_sample delay_mem [cor_pkg::VECTORS][cor_pkg::CHANNELS][cor_pkg::DELAY_DEPTH];
    logic        odd_grp;
    logic        bank_sel;
    int unsigned delay_slot;
    logic [2:0]  rot_step;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("channelizer_output_rotator regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic predict_rotated_lanes(input cor_pkg::t_in_item item);
        cor_pkg::t_sample   fresh [cor_pkg::VECTORS][cor_pkg::CHANNELS];
        cor_pkg::t_sample   late  [cor_pkg::VECTORS][cor_pkg::CHANNELS];
        cor_pkg::t_sample   rot   [cor_pkg::VECTORS][cor_pkg::CHANNELS];
        int unsigned        ch;
        int unsigned        base;
        int unsigned        shift;
        cor_pkg::t_out_item res;
        ch = 2 * item.lane + odd_grp;
        bank_mem[bank_sel][0][ch] = item.word_low[31:0];
        bank_mem[bank_sel][1][ch] = item.word_low[63:32];
        bank_mem[bank_sel][2][ch] = item.word_high[31:0];
        bank_mem[bank_sel][3][ch] = item.word_high[63:32];
        if (item.lane != cor_pkg::LAST_LANE)
            return;
        base = odd_grp ? 2 : 0;
        for (int v = 0; v < cor_pkg::VECTORS; v++) begin
            for (int m = 0; m < cor_pkg::CHANNELS; m++) begin
                fresh[v][m] = bank_mem[bank_sel ^ 1'b1][base + v][m];
                late[v][m] = delay_mem[v][m][delay_slot];
                delay_mem[v][m][delay_slot] = fresh[v][m];
            end
        end
        delay_slot = (delay_slot >= cor_pkg::DELAY_DEPTH - 1) ? 0 : delay_slot + 1;
        for (int v = 0; v < cor_pkg::VECTORS; v++) begin
            shift = (2 * ((rot_step + v) % 8)) % cor_pkg::CHANNELS;
            for (int m = 0; m < cor_pkg::CHANNELS; m++)
                rot[v][m] = late[v][(m + shift) % cor_pkg::CHANNELS];
        end
        rot_step = rot_step + 3'd2;
        if (odd_grp)
            bank_sel = ~bank_sel;
        odd_grp = ~odd_grp;
        for (int i = 0; i < cor_pkg::LANES; i++) begin
            res.out_lane  = cor_pkg::LANE_W'(i);
            res.out_low   = {rot[0][i + 8], rot[0][i]};
            res.out_high  = {rot[1][i + 8], rot[1][i]};
            res.last      = (i == cor_pkg::LANES - 1);
            rotated_words_q.push_back(res);
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        cor_pkg::t_out_item want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (rotated_words_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual lane %0d %h %h %b",
                         $time, out_bus.data.out_lane, out_bus.data.out_low,
                         out_bus.data.out_high, out_bus.data.last);
                mismatch_count++;
            end else begin
                want = rotated_words_q.pop_front();
                check_field("out_lane", 64'(want.out_lane), 64'(out_bus.data.out_lane));
                check_field("out_low", want.out_low, out_bus.data.out_low);
                check_field("out_high", want.out_high, out_bus.data.out_high);
                check_field("last", 64'(want.last), 64'(out_bus.data.last));
            end
        end
    end

    // hold valid high until the request is taken, then predict
    task automatic send_word(input cor_pkg::t_in_item item);
        while ($urandom_range(99) < src_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.data  <= item;
        do
            @(posedge i_clk);
        while (!in_bus.ready);
        predict_rotated_lanes(item);
    endtask

    function automatic cor_pkg::t_sample rand_sample();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return cor_pkg::t_sample'($urandom);
        endcase
    endfunction

    function automatic cor_pkg::t_in_item make_word(input int lane);
        cor_pkg::t_in_item item;
        item.lane      = cor_pkg::LANE_W'(lane);
        item.word_low  = {rand_sample(), rand_sample()};
        item.word_high = {rand_sample(), rand_sample()};
        return item;
    endfunction

    function automatic cor_pkg::t_in_item tagged_word(input int lane);
        cor_pkg::t_in_item item;
        item.lane      = cor_pkg::LANE_W'(lane);
        item.word_low  = {4'hC, 20'h0, 4'(lane), 4'd1, 4'hC, 20'h0, 4'(lane), 4'd0};
        item.word_high = {4'hC, 20'h0, 4'(lane), 4'd3, 4'hC, 20'h0, 4'(lane), 4'd2};
        return item;
    endfunction

    task automatic test_full_groups();
        cor_pkg::t_in_item item;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        for (int lane = 0; lane < cor_pkg::LANES; lane++) begin
            item.lane      = cor_pkg::LANE_W'(lane);
            item.word_low  = '1;
            item.word_high = '1;
            send_word(item);
        end
        for (int lane = 0; lane < cor_pkg::LANES; lane++)
            send_word(tagged_word(lane));
    endtask

    task automatic test_broken_groups();
        cor_pkg::t_in_item item;
        item = tagged_word(7);
        item.word_low = '0;
        send_word(item);
        send_word(tagged_word(3));
        send_word(tagged_word(1));
        send_word(make_word(7));
        send_word(make_word(5));
        send_word(make_word(5));
        send_word(make_word(7));
        send_word(make_word(0));
        send_word(make_word(7));
    endtask

    task automatic run_group_traffic(input int n_items);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                for (int lane = 0; lane < cor_pkg::LANES; lane++)
                    send_word(make_word(lane));
                sent += cor_pkg::LANES;
            end else if (pick < 90) begin
                len = $urandom_range(1, 9);
                for (int j = 0; j < len - 1; j++)
                    send_word(make_word($urandom_range(cor_pkg::LANES - 1)));
                if ($urandom_range(9) < 7)
                    send_word(make_word(cor_pkg::LANES - 1));
                else
                    send_word(make_word($urandom_range(cor_pkg::LANES - 1)));
                sent += len;
            end else begin
                len = $urandom_range(1, 4);
                for (int j = 0; j < len; j++)
                    send_word(make_word($urandom_range(cor_pkg::LANES - 1)));
                sent += len;
            end
        end
    endtask

    task automatic test_streaming();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        run_group_traffic(100);
    endtask

    task automatic test_sender_idle();
        src_idle_pct  = 88;
        snk_stall_pct = 0;
        run_group_traffic(98);
    endtask

    task automatic test_receiver_stall();
        src_idle_pct  = 0;
        snk_stall_pct = 88;
        run_group_traffic(98);
    endtask

    task automatic test_mixed_idle();
        src_idle_pct  = 27;
        snk_stall_pct = 27;
        run_group_traffic(100);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_bus.valid   = 1'b0;
        in_bus.data    = '0;
        out_bus.ready  = 1'b0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        odd_grp        = 1'b0;
        bank_sel       = 1'b0;
        delay_slot     = 0;
        rot_step       = '0;
        for (int m = 0; m < cor_pkg::CHANNELS; m++) begin
            for (int k = 0; k < cor_pkg::WORD_SAMPLES; k++) begin
                bank_mem[0][k][m] = '0;
                bank_mem[1][k][m] = '0;
            end
            for (int s = 0; s < cor_pkg::DELAY_DEPTH; s++) begin
                delay_mem[0][m][s] = '0;
                delay_mem[1][m][s] = '0;
            end
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_full_groups();
        test_broken_groups();
        test_streaming();
        test_sender_idle();
        test_receiver_stall();
        test_mixed_idle();

        in_bus.valid <= 1'b0;
        while (rotated_words_q.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("channelizer_output_rotator regression: pass");
        end else begin
            $display("channelizer_output_rotator regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/cor_pkg.sv
hdl/cor_ifs.sv
hdl/cor_lane.sv
hdl/cor_merge.sv
hdl/channelizer_output_rotator.sv
tb/sv/channelizer_output_rotator_test.sv
